@@ design/sdd_pkg.sv @@
// Shared types and constants for the signed base-b digit decomposition unit.
// No dependencies; sdd_front, sdd_back, the top level and sdd_checker import this package.
`default_nettype none

package sdd_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CfgBaseWidth   = 33;
  localparam int unsigned CfgLevelsWidth = 7;
  localparam int unsigned LevelWidth     = 6;

  // Configuration register indexes.
  localparam logic CFG_BASE   = 1'b0;
  localparam logic CFG_LEVELS = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CfgBaseWidth-1:0]   BaseReset   = 33'd2;
  localparam logic [CfgLevelsWidth-1:0] LevelsReset = 7'd1;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_FETCH,
    ST_DIV,
    ST_HOLD
  } sdd_state_t;

endpackage

`default_nettype wire

@@ design/sdd_fifo.sv @@
// Two-entry item queue between the front end and the back end.
// Depends on no package; data width is a parameter.
`default_nettype none

module sdd_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data,
  output logic                   not_empty
);

  logic [DATA_W-1:0] mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  // Storage is written only on a push.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/sdd_front.sv @@
// Front end: configuration registers, their clamping, and input classification.
// Depends on sdd_pkg.
`default_nettype none

module sdd_front #(
  parameter int unsigned COEFF_WIDTH = 64,
  parameter int unsigned BASE_WIDTH  = 33,
  parameter int unsigned MAX_LEVELS  = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic                                cfg_index,
  input  wire logic [sdd_pkg::CfgBaseWidth-1:0]    cfg_data,
  input  wire logic [COEFF_WIDTH-1:0]              coefficient,
  output logic                                     neg,
  output logic [COEFF_WIDTH-1:0]                   mag,
  output logic [BASE_WIDTH-1:0]                    eff_base,
  output logic [sdd_pkg::LevelWidth-1:0]           last_level
);
  import sdd_pkg::*;

  localparam logic [CfgBaseWidth-1:0]   TopBase = CfgBaseWidth'(1) << (BASE_WIDTH - 1);
  localparam logic [CfgLevelsWidth-1:0] MaxLv   = CfgLevelsWidth'(MAX_LEVELS);

  logic [CfgBaseWidth-1:0]   base;
  logic [CfgLevelsWidth-1:0] levels;
  logic [CfgBaseWidth-1:0]   base_clamped;
  logic [CfgLevelsWidth-1:0] levels_clamped;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      base   <= BaseReset;
      levels <= LevelsReset;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BASE:   base   <= cfg_data;
        CFG_LEVELS: levels <= cfg_data[CfgLevelsWidth-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp base into [2, 2^(BASE_WIDTH-1)] and levels into [1, MAX_LEVELS].
  always_comb begin
    base_clamped = base;
    if (base < CfgBaseWidth'(2)) begin
      base_clamped = CfgBaseWidth'(2);
    end else if (base > TopBase) begin
      base_clamped = TopBase;
    end
    levels_clamped = levels;
    if (levels == '0) begin
      levels_clamped = CfgLevelsWidth'(1);
    end else if (levels > MaxLv) begin
      levels_clamped = MaxLv;
    end
  end

  assign eff_base   = base_clamped[BASE_WIDTH-1:0];
  assign last_level = LevelWidth'(levels_clamped - CfgLevelsWidth'(1));

  // Split the coefficient into sign and exact magnitude.
  assign neg = coefficient[COEFF_WIDTH-1];
  assign mag = neg ? (~coefficient + COEFF_WIDTH'(1)) : coefficient;

endmodule

`default_nettype wire

@@ design/sdd_back.sv @@
// Back end: restoring divider that peels off one digit per pass, and the
// output register. Depends on sdd_pkg.
`default_nettype none

module sdd_back #(
  parameter int unsigned COEFF_WIDTH = 64,
  parameter int unsigned BASE_WIDTH  = 33
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_valid,
  input  wire logic                           q_neg,
  input  wire logic                           q_last,
  input  wire logic [COEFF_WIDTH-1:0]         q_mag,
  input  wire logic [BASE_WIDTH-1:0]          q_base,
  input  wire logic [sdd_pkg::LevelWidth-1:0] q_last_level,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [sdd_pkg::LevelWidth-1:0]      level,
  output logic [BASE_WIDTH-1:0]               digit,
  output logic                                digit_last,
  output logic                                poly_last
);
  import sdd_pkg::*;

  localparam int unsigned CntW = $clog2(COEFF_WIDTH);

  sdd_state_t            state;
  sdd_state_t            state_next;
  logic [COEFF_WIDTH-1:0] quo;
  logic [BASE_WIDTH-1:0]  rem;
  logic [CntW-1:0]        cnt;
  logic                   neg;
  logic                   clast;
  logic [BASE_WIDTH-1:0]  base;
  logic [LevelWidth-1:0]  last_level;
  logic [LevelWidth-1:0]  lvl;
  logic [BASE_WIDTH-1:0]  trial;
  logic                   ge;
  logic                   out_free;
  logic                   emit;
  logic                   div_done;
  logic                   fin;

  assign out_free = !out_valid || out_ready;
  assign div_done = (cnt == CntW'(COEFF_WIDTH - 1));
  assign fin      = (lvl == last_level);

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem[BASE_WIDTH-2:0], quo[COEFF_WIDTH-1]};
  assign ge    = (trial >= base);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_FETCH: begin
        if (q_valid) begin
          state_next = (q_mag == '0) ? ST_HOLD : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          if (fin) begin
            state_next = ST_FETCH;
          end else if (quo == '0) begin
            state_next = ST_HOLD;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      default: state_next = ST_FETCH;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    case (state)
      ST_FETCH: q_pop = q_valid;
      ST_HOLD:  emit  = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FETCH;
    end else begin
      state <= state_next;
    end
  end

  // Divider datapath and per-item context.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      quo        <= q_mag;
      rem        <= '0;
      cnt        <= '0;
      neg        <= q_neg;
      clast      <= q_last;
      base       <= q_base;
      last_level <= q_last_level;
      lvl        <= '0;
    end else if (state == ST_DIV) begin
      quo <= {quo[COEFF_WIDTH-2:0], ge};
      rem <= ge ? (trial - base) : trial;
      cnt <= cnt + CntW'(1);
    end else if (emit) begin
      rem <= '0;
      cnt <= '0;
      lvl <= lvl + LevelWidth'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      level      <= lvl;
      digit      <= neg ? (~rem + BASE_WIDTH'(1)) : rem;
      digit_last <= fin;
      poly_last  <= fin && clast;
    end
  end

endmodule

`default_nettype wire

@@ design/signed_base_digit_decompose_unit.sv @@
// Top level of the signed base-b digit decomposition unit.
// Depends on sdd_pkg, sdd_front, sdd_fifo and sdd_back.
//
// Each coefficient item is split into sign and magnitude at the input and
// queued; the back end then produces one digit item per level, least
// significant first, each carrying the coefficient's sign. Each item is
// fetched from the queue, and each digit is divided out in the
// one-bit-per-cycle restoring divider and then handed to the output
// register; once the remaining magnitude is zero, further digits are
// handed on without dividing. The two-entry queue lets new items be
// accepted while earlier ones are divided.
`default_nettype none

module signed_base_digit_decompose_unit #(
  parameter int unsigned COEFF_WIDTH = 64,
  parameter int unsigned BASE_WIDTH  = 33,
  parameter int unsigned MAX_LEVELS  = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic                             cfg_index,
  input  wire logic [sdd_pkg::CfgBaseWidth-1:0] cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [COEFF_WIDTH-1:0]           coefficient,
  input  wire logic                             coeff_last,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [sdd_pkg::LevelWidth-1:0]        level,
  output logic [BASE_WIDTH-1:0]                 digit,
  output logic                                  digit_last,
  output logic                                  poly_last
);
  import sdd_pkg::*;

  localparam int unsigned EntryW = COEFF_WIDTH + BASE_WIDTH + LevelWidth + 2;

  logic                   f_neg;
  logic [COEFF_WIDTH-1:0] f_mag;
  logic [BASE_WIDTH-1:0]  f_base;
  logic [LevelWidth-1:0]  f_last_level;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  logic [EntryW-1:0]      q_data;
  logic                   push;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  sdd_front #(
    .COEFF_WIDTH(COEFF_WIDTH),
    .BASE_WIDTH (BASE_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .coefficient(coefficient),
    .neg        (f_neg),
    .mag        (f_mag),
    .eff_base   (f_base),
    .last_level (f_last_level)
  );

  sdd_fifo #(
    .DATA_W(EntryW)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({f_neg, coeff_last, f_mag, f_base, f_last_level}),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_data),
    .not_empty(q_valid)
  );

  sdd_back #(
    .COEFF_WIDTH(COEFF_WIDTH),
    .BASE_WIDTH (BASE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_neg       (q_data[EntryW-1]),
    .q_last      (q_data[EntryW-2]),
    .q_mag       (q_data[EntryW-3 -: COEFF_WIDTH]),
    .q_base      (q_data[LevelWidth +: BASE_WIDTH]),
    .q_last_level(q_data[LevelWidth-1:0]),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .level       (level),
    .digit       (digit),
    .digit_last  (digit_last),
    .poly_last   (poly_last)
  );

endmodule

`default_nettype wire

@@ design/sdd_checker.sv @@
// Port-level checks for the digit decomposition unit, bound to its top level.
// Depends on sdd_pkg and signed_base_digit_decompose_unit.
`default_nettype none

module sdd_checker #(
  parameter int unsigned BASE_WIDTH = 33
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [sdd_pkg::LevelWidth-1:0] level,
  input wire logic [BASE_WIDTH-1:0]          digit,
  input wire logic                           digit_last,
  input wire logic                           poly_last
);
  import sdd_pkg::*;

  // No item is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled item holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digit) && $stable(level))
    else $error("stalled item changed");

  // The polynomial end only falls on a coefficient's last digit.
  a_poly_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && poly_last |-> digit_last)
    else $error("poly_last without digit_last");

  // The highest level position always ends a coefficient.
  a_top_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && (level == {LevelWidth{1'b1}}) |-> digit_last)
    else $error("top level not marked last");

endmodule

bind signed_base_digit_decompose_unit sdd_checker #(
  .BASE_WIDTH(BASE_WIDTH)
) u_sdd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .level     (level),
  .digit     (digit),
  .digit_last(digit_last),
  .poly_last (poly_last)
);

`default_nettype wire
